// ===== design/gctl_pkg.sv =====
// Package of the great-circle tour length block: fixed-point types,
// Q30 constants, the arctangent table and the angle reduction function.
// Depends on nothing; every other file imports it.
package gctl_pkg;

   localparam int ANGLE_FRAC_BITS = 16;
   localparam int CORDIC_STEPS = 30;
   localparam int SQRT_STEPS = 32;

   typedef logic signed [23:0] lat_type;
   typedef logic signed [24:0] lon_type;
   typedef logic signed [25:0] ang_type;
   typedef logic [47:0] dist_type;
   typedef logic signed [33:0] q_type;
   typedef logic signed [67:0] prod_type;
   typedef logic [62:0] root_type;
   typedef logic [15:0] radius_type;

   localparam radius_type RADIUS_RESET = 16'd6371;
   localparam q_type Q30_ONE = 34'sd1073741824;
   localparam q_type CORDIC_GAIN_INV = 34'sd652032874;
   localparam q_type DEG_TO_RAD_Q30 = 34'sd18740330;
   localparam q_type HALF_PI_Q30 = 34'sd1686629713;
   localparam dist_type SUM_MAX = 48'hFFFF_FFFF_FFFF;

   localparam logic signed [26:0] FULL_DEG = 27'(360 << ANGLE_FRAC_BITS);
   localparam logic signed [26:0] HALF_DEG = 27'(180 << ANGLE_FRAC_BITS);
   localparam logic signed [26:0] QUARTER_DEG = 27'(90 << ANGLE_FRAC_BITS);

   typedef enum logic [3:0] {
      ST_IDLE, ST_ANG_MUL, ST_ROT_LOAD, ST_ROT, ST_MUL_SS, ST_MUL_CC, ST_MUL_CD,
      ST_CLAMP, ST_MUL_SQ, ST_SQRT_LOAD, ST_SQRT, ST_VEC_LOAD, ST_VEC, ST_MUL_LEG,
      ST_ACC, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic vector;
      q_type x0;
      q_type y0;
      q_type z0;
   } cordic_ctrl_type;

   typedef struct packed {
      logic flip;
      logic signed [24:0] deg;
   } fold_type;

   function automatic q_type arctan_q30(input logic [4:0] idx);
      q_type r;
      case (idx)
         5'd0: r = 34'sd843314857;
         5'd1: r = 34'sd497837829;
         5'd2: r = 34'sd263043837;
         5'd3: r = 34'sd133525159;
         5'd4: r = 34'sd67021687;
         5'd5: r = 34'sd33543516;
         5'd6: r = 34'sd16775851;
         5'd7: r = 34'sd8388437;
         5'd8: r = 34'sd4194283;
         5'd9: r = 34'sd2097149;
         5'd10: r = 34'sd1048576;
         5'd11: r = 34'sd524288;
         5'd12: r = 34'sd262144;
         5'd13: r = 34'sd131072;
         5'd14: r = 34'sd65536;
         5'd15: r = 34'sd32768;
         5'd16: r = 34'sd16384;
         5'd17: r = 34'sd8192;
         5'd18: r = 34'sd4096;
         5'd19: r = 34'sd2048;
         5'd20: r = 34'sd1024;
         5'd21: r = 34'sd512;
         5'd22: r = 34'sd256;
         5'd23: r = 34'sd128;
         5'd24: r = 34'sd64;
         5'd25: r = 34'sd32;
         5'd26: r = 34'sd16;
         5'd27: r = 34'sd8;
         5'd28: r = 34'sd4;
         5'd29: r = 34'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Reduces an angle to [-180,180) degrees and folds it into [-90,90].
   // A fold means the cosine has to be negated afterwards.
   function automatic fold_type fold_angle(input ang_type a);
      logic signed [26:0] d;
      fold_type f;
      d = 27'(a);
      if (d >= FULL_DEG) d = d - FULL_DEG;
      if (d < 0) d = d + FULL_DEG;
      if (d < 0) d = d + FULL_DEG;
      if (d >= HALF_DEG) d = d - FULL_DEG;
      f.flip = 1'b0;
      if (d > QUARTER_DEG) begin
         d = HALF_DEG - d;
         f.flip = 1'b1;
      end else if (d < -QUARTER_DEG) begin
         d = -HALF_DEG - d;
         f.flip = 1'b1;
      end
      f.deg = d[24:0];
      return f;
   endfunction

endpackage

// ===== design/gctl_if.sv =====
// Valid/ready channel interfaces for city beats in and tour length beats out.
// Depends on gctl_pkg for the field types.
interface gctl_req_if import gctl_pkg::*; ();
   logic valid;
   logic ready;
   lat_type latitude;
   lon_type longitude;
   logic is_last;
   modport source(output valid, latitude, longitude, is_last, input ready);
   modport sink(input valid, latitude, longitude, is_last, output ready);
endinterface

interface gctl_rsp_if import gctl_pkg::*; ();
   logic valid;
   logic ready;
   dist_type total_distance;
   logic saturated;
   modport source(output valid, total_distance, saturated, input ready);
   modport sink(input valid, total_distance, saturated, output ready);
endinterface

// ===== design/gctl_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on gctl_pkg.
module gctl_mul import gctl_pkg::*; (
   input logic clock,
   input q_type a,
   input q_type b,
   output prod_type p
);
   prod_type p_ff;

   always_ff @(posedge clock) begin
      p_ff <= prod_type'(a) * prod_type'(b);
   end

   assign p = p_ff;
endmodule

// ===== design/gctl_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on gctl_pkg for the arctangent table and the control struct.
module gctl_cordic import gctl_pkg::*; (
   input logic clock,
   input logic reset,
   input cordic_ctrl_type ctrl,
   output logic done,
   output q_type x,
   output q_type y,
   output q_type z
);
   q_type x_ff, y_ff, z_ff;
   logic [4:0] cnt_ff;
   logic busy_ff, done_ff, vector_ff;
   q_type dx, dy, at;
   logic dir;

   always_comb begin
      dx = y_ff >>> cnt_ff;
      dy = x_ff >>> cnt_ff;
      at = arctan_q30(cnt_ff);
      // Vectoring drives y toward zero, rotation drives z toward zero.
      dir = vector_ff ? !(y_ff > 0) : (z_ff >= 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.load) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         x_ff <= ctrl.x0;
         y_ff <= ctrl.y0;
         z_ff <= ctrl.z0;
         vector_ff <= ctrl.vector;
      end else if (busy_ff) begin
         if (dir) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + at;
         end
      end
   end

   assign done = done_ff;
   assign x = x_ff;
   assign y = y_ff;
   assign z = z_ff;
endmodule

// ===== design/gctl_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on gctl_pkg.
module gctl_isqrt import gctl_pkg::*; (
   input logic clock,
   input logic reset,
   input logic load,
   input root_type op_in,
   output logic done,
   output q_type root
);
   root_type op_ff, res_ff, bit_ff, trial;
   logic [4:0] cnt_ff;
   logic busy_ff, done_ff;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (load) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(SQRT_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff <= op_in;
         res_ff <= '0;
         bit_ff <= {1'b1, 62'd0};
      end else if (busy_ff) begin
         if (op_ff >= trial) begin
            op_ff <= op_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = q_type'(res_ff[32:0]);
endmodule

// ===== design/great_circle_tour_length_core.sv =====
// Great-circle tour length core. Cities arrive on req_chan, one beat per
// city in visiting order (latitude, longitude in degrees with 16 fraction
// bits, is_last on the final city). Each leg gets its central angle from
// the spherical law of cosines, is scaled by the radius register written
// through csr_write_enable/csr_write_data, and is added to a running sum.
// On a beat with is_last set the closing leg back to the first city is
// added and one beat with the total (1/256 radius units) leaves on
// rsp_chan; saturated marks a sum clamped at 2^48-1.
// The first city of a tour is only stored unless it is also the last.
// Every leg runs three 30-step CORDIC rotations, a 32-step square root
// and a 30-step CORDIC vectoring pass on the shared units, plus eight
// multiplies on the one multiplier.
// req_chan.ready is low while a leg is being worked on. The result sits
// in an output register, so a stalled receiver blocks the block only when
// the next tour finishes before the previous total has been taken.
// Reset clears the tour and sets the radius to 6371.
module great_circle_tour_length_core import gctl_pkg::*; (
   input logic clock,
   input logic reset,
   gctl_req_if.sink req_chan,
   gctl_rsp_if.source rsp_chan,
   input logic csr_write_enable,
   input radius_type csr_write_data
);
   state_type state_ff, state_in;
   radius_type radius_ff;
   logic have_first_ff, closing_ff, last_ff, rsp_valid_ff, clamped_ff;
   logic [1:0] sel_ff;
   dist_type sum_ff, out_dist_ff;
   logic out_sat_ff;
   lat_type first_lat_ff, prev_lat_ff, la_ff, lb_ff;
   lon_type first_lon_ff, prev_lon_ff, loa_ff, lob_ff;
   logic flip_ff;
   q_type sa_ff, ca_ff, sb_ff, cb_ff, cd_ff, t1_ff, c_ff;

   q_type mul_a, mul_b, p_shr, angle, arg_c, sqrt_root;
   prod_type p;
   ang_type ang_src;
   fold_type fold;
   cordic_ctrl_type cordic_ctrl;
   logic cordic_done, sqrt_done, sqrt_load, accept, out_fire;
   q_type cx, cy, cz;
   logic signed [34:0] arg_sum;
   logic [48:0] rnd, sum_new;
   logic [26:0] leg;
   root_type sqrt_op;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign out_fire = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   gctl_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p(p));

   gctl_cordic u_cordic (
      .clock(clock), .reset(reset), .ctrl(cordic_ctrl), .done(cordic_done),
      .x(cx), .y(cy), .z(cz)
   );

   gctl_isqrt u_isqrt (
      .clock(clock), .reset(reset), .load(sqrt_load), .op_in(sqrt_op),
      .done(sqrt_done), .root(sqrt_root)
   );

   // Datapath glue around the shared units.
   always_comb begin
      p_shr = q_type'(p >>> 30);
      case (sel_ff)
         2'd0: ang_src = ang_type'(la_ff);
         2'd1: ang_src = ang_type'(lb_ff);
         default: ang_src = ang_type'(loa_ff) - ang_type'(lob_ff);
      endcase
      fold = fold_angle(ang_src);
      angle = (cz < 0) ? '0 : cz;
      arg_sum = 35'(t1_ff) + 35'(p_shr);
      if (arg_sum > 35'(Q30_ONE)) arg_c = Q30_ONE;
      else if (arg_sum < -35'(Q30_ONE)) arg_c = -Q30_ONE;
      else arg_c = q_type'(arg_sum);
      sqrt_op = {3'b001, 60'd0} - p[62:0];
      rnd = p[48:0] + 49'(1 << 21);
      leg = rnd[48:22];
      sum_new = {1'b0, sum_ff} + 49'(leg);
   end

   always_comb begin
      state_in = state_ff;
      mul_a = '0;
      mul_b = '0;
      sqrt_load = 1'b0;
      cordic_ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (have_first_ff || req_chan.is_last)) state_in = ST_ANG_MUL;
         end
         ST_ANG_MUL: begin
            mul_a = q_type'(fold.deg);
            mul_b = DEG_TO_RAD_Q30;
            state_in = ST_ROT_LOAD;
         end
         ST_ROT_LOAD: begin
            cordic_ctrl.load = 1'b1;
            cordic_ctrl.x0 = CORDIC_GAIN_INV;
            cordic_ctrl.z0 = q_type'(p >>> ANGLE_FRAC_BITS);
            state_in = ST_ROT;
         end
         ST_ROT: begin
            if (cordic_done) state_in = (sel_ff == 2'd2) ? ST_MUL_SS : ST_ANG_MUL;
         end
         ST_MUL_SS: begin
            mul_a = sa_ff;
            mul_b = sb_ff;
            state_in = ST_MUL_CC;
         end
         ST_MUL_CC: begin
            mul_a = ca_ff;
            mul_b = cb_ff;
            state_in = ST_MUL_CD;
         end
         ST_MUL_CD: begin
            mul_a = p_shr;
            mul_b = cd_ff;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: state_in = ST_MUL_SQ;
         ST_MUL_SQ: begin
            mul_a = c_ff;
            mul_b = c_ff;
            state_in = ST_SQRT_LOAD;
         end
         ST_SQRT_LOAD: begin
            sqrt_load = 1'b1;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (sqrt_done) state_in = ST_VEC_LOAD;
         end
         ST_VEC_LOAD: begin
            cordic_ctrl.load = 1'b1;
            cordic_ctrl.vector = 1'b1;
            // A negative cosine is turned by a quarter turn first.
            if (c_ff < 0) begin
               cordic_ctrl.x0 = sqrt_root;
               cordic_ctrl.y0 = -c_ff;
               cordic_ctrl.z0 = HALF_PI_Q30;
            end else begin
               cordic_ctrl.x0 = c_ff;
               cordic_ctrl.y0 = sqrt_root;
            end
            state_in = ST_VEC;
         end
         ST_VEC: begin
            if (cordic_done) state_in = ST_MUL_LEG;
         end
         ST_MUL_LEG: begin
            mul_a = q_type'({1'b0, radius_ff});
            mul_b = angle;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (closing_ff) state_in = ST_OUT;
            else if (last_ff) state_in = ST_ANG_MUL;
            else state_in = ST_IDLE;
         end
         ST_OUT: begin
            if (out_fire) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control and tour state.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         have_first_ff <= 1'b0;
         closing_ff <= 1'b0;
         last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clamped_ff <= 1'b0;
         sum_ff <= '0;
         sel_ff <= '0;
      end else begin
         if (csr_write_enable) radius_ff <= csr_write_data;
         // A new total may replace the one being taken in the same cycle.
         rsp_valid_ff <= out_fire || (rsp_valid_ff && !rsp_chan.ready);
         if (accept) begin
            sel_ff <= '0;
            last_ff <= req_chan.is_last;
            closing_ff <= !have_first_ff;
            if (!have_first_ff) begin
               have_first_ff <= 1'b1;
               sum_ff <= '0;
               clamped_ff <= 1'b0;
            end
         end
         if (state_ff == ST_ROT && cordic_done) sel_ff <= sel_ff + 2'd1;
         if (state_ff == ST_ACC) begin
            if (sum_new > {1'b0, SUM_MAX}) begin
               sum_ff <= SUM_MAX;
               clamped_ff <= 1'b1;
            end else begin
               sum_ff <= sum_new[47:0];
            end
            if (!closing_ff && last_ff) begin
               closing_ff <= 1'b1;
               sel_ff <= '0;
            end
         end
         if (out_fire) begin
            have_first_ff <= 1'b0;
         end
      end
   end

   // Operand and intermediate registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         prev_lat_ff <= req_chan.latitude;
         prev_lon_ff <= req_chan.longitude;
         lb_ff <= req_chan.latitude;
         lob_ff <= req_chan.longitude;
         if (have_first_ff) begin
            la_ff <= prev_lat_ff;
            loa_ff <= prev_lon_ff;
         end else begin
            first_lat_ff <= req_chan.latitude;
            first_lon_ff <= req_chan.longitude;
            la_ff <= req_chan.latitude;
            loa_ff <= req_chan.longitude;
         end
      end
      if (state_ff == ST_ACC && !closing_ff && last_ff) begin
         la_ff <= lb_ff;
         loa_ff <= lob_ff;
         lb_ff <= first_lat_ff;
         lob_ff <= first_lon_ff;
      end
      if (state_ff == ST_ANG_MUL) flip_ff <= fold.flip;
      if (state_ff == ST_ROT && cordic_done) begin
         case (sel_ff)
            2'd0: begin
               sa_ff <= cy;
               ca_ff <= flip_ff ? -cx : cx;
            end
            2'd1: begin
               sb_ff <= cy;
               cb_ff <= flip_ff ? -cx : cx;
            end
            default: cd_ff <= flip_ff ? -cx : cx;
         endcase
      end
      if (state_ff == ST_MUL_CC) t1_ff <= p_shr;
      if (state_ff == ST_CLAMP) c_ff <= arg_c;
      if (out_fire) begin
         out_dist_ff <= sum_ff;
         out_sat_ff <= clamped_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.total_distance = out_dist_ff;
   assign rsp_chan.saturated = out_sat_ff;

`ifndef ASSERT_OFF
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result beat raised outside the output state");
   a_sat_is_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_sat_ff) |-> (out_dist_ff == SUM_MAX))
      else $error("saturated total is not the maximum");
   a_sum_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |=> (sum_ff >= $past(sum_ff)))
      else $error("running sum decreased on a leg");
   a_cordic_owner: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> (state_ff == ST_ROT || state_ff == ST_VEC))
      else $error("CORDIC finished while the sequencer was not waiting");
`endif
endmodule
